>>> rtl/cau_pkg.sv
package cau_pkg;

    localparam int CAU_DATA_WIDTH = 16;
    localparam int CAU_FRAC_BITS  = 8;
    // magnitude width of a product sum, remainder width of the divider
    localparam int CAU_MAG_WIDTH  = 2 * CAU_DATA_WIDTH + 1;
    localparam int CAU_REM_WIDTH  = CAU_MAG_WIDTH + CAU_DATA_WIDTH;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cau_cmd_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } cau_status_t;

    typedef struct packed {
        cau_cmd_t                         cmd;
        logic signed [CAU_DATA_WIDTH-1:0] a_re;
        logic signed [CAU_DATA_WIDTH-1:0] a_im;
        logic signed [CAU_DATA_WIDTH-1:0] b_re;
        logic signed [CAU_DATA_WIDTH-1:0] b_im;
    } cau_in_t;

    typedef struct packed {
        logic signed [CAU_DATA_WIDTH-1:0] res_re;
        logic signed [CAU_DATA_WIDTH-1:0] res_im;
        cau_status_t                      status;
    } cau_out_t;

    typedef struct packed {
        logic div;
        logic neg_re;
        logic neg_im;
        logic ovf_re;
        logic ovf_im;
    } cau_ctl_t;

    typedef struct packed {
        logic                      flag;
        logic [CAU_DATA_WIDTH-1:0] val;
    } cau_sat_t;

    function automatic logic [CAU_MAG_WIDTH-1:0] cau_abs(
        input logic signed [CAU_MAG_WIDTH-1:0] x);
        cau_abs = x[CAU_MAG_WIDTH-1] ? CAU_MAG_WIDTH'(-x) : CAU_MAG_WIDTH'(x);
    endfunction

    // Clamp a sign-magnitude value to the signed data range.
    function automatic cau_sat_t cau_sat(input logic neg,
                                         input logic [CAU_MAG_WIDTH-1:0] mag);
        logic [CAU_MAG_WIDTH-1:0] neg_mag;
        logic [CAU_MAG_WIDTH-1:0] pos_max;
        logic [CAU_MAG_WIDTH-1:0] negated;
        cau_sat_t                 r;
        neg_mag = CAU_MAG_WIDTH'(1) << (CAU_DATA_WIDTH - 1);
        pos_max = neg_mag - CAU_MAG_WIDTH'(1);
        negated = CAU_MAG_WIDTH'(0) - mag;
        r.flag  = 1'b0;
        if (neg) begin
            if (mag > neg_mag) begin
                r.flag = 1'b1;
                r.val  = {1'b1, {(CAU_DATA_WIDTH-1){1'b0}}};
            end else begin
                r.val = negated[CAU_DATA_WIDTH-1:0];
            end
        end else begin
            if (mag > pos_max) begin
                r.flag = 1'b1;
                r.val  = {1'b0, {(CAU_DATA_WIDTH-1){1'b1}}};
            end else begin
                r.val = mag[CAU_DATA_WIDTH-1:0];
            end
        end
        cau_sat = r;
    endfunction

endpackage

>>> rtl/cau_cell.sv
module cau_cell import cau_pkg::*; #(
    parameter int SHIFT = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     v_in,
    output logic                     rdy_out,
    input  cau_ctl_t                 ctl_in,
    input  cau_out_t                 res_in,
    input  logic [CAU_REM_WIDTH-1:0] rre_in,
    input  logic [CAU_REM_WIDTH-1:0] rim_in,
    input  logic [CAU_MAG_WIDTH-1:0] d_in,
    input  logic [CAU_DATA_WIDTH-1:0] qre_in,
    input  logic [CAU_DATA_WIDTH-1:0] qim_in,
    output logic                     v_out,
    input  logic                     rdy_in,
    output cau_ctl_t                 ctl_out,
    output cau_out_t                 res_out,
    output logic [CAU_REM_WIDTH-1:0] rre_out,
    output logic [CAU_REM_WIDTH-1:0] rim_out,
    output logic [CAU_MAG_WIDTH-1:0] d_out,
    output logic [CAU_DATA_WIDTH-1:0] qre_out,
    output logic [CAU_DATA_WIDTH-1:0] qim_out
);

    logic                      v_reg;
    cau_ctl_t                  ctl_reg;
    cau_out_t                  res_reg;
    logic [CAU_REM_WIDTH-1:0]  rre_reg, rim_reg, rre_next, rim_next;
    logic [CAU_MAG_WIDTH-1:0]  d_reg;
    logic [CAU_DATA_WIDTH-1:0] qre_reg, qim_reg, qre_next, qim_next;
    logic [CAU_REM_WIDTH-1:0]  dsh;
    logic                      ge_re, ge_im;

    // one restoring step: try the divisor at this bit weight
    always_comb begin
        dsh      = CAU_REM_WIDTH'(d_in) << SHIFT;
        ge_re    = rre_in >= dsh;
        ge_im    = rim_in >= dsh;
        rre_next = ge_re ? rre_in - dsh : rre_in;
        rim_next = ge_im ? rim_in - dsh : rim_in;
        qre_next = {qre_in[CAU_DATA_WIDTH-2:0], ge_re};
        qim_next = {qim_in[CAU_DATA_WIDTH-2:0], ge_im};
    end

    assign rdy_out = !v_reg || rdy_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (rdy_out) begin
            v_reg <= v_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_out && v_in) begin
            ctl_reg <= ctl_in;
            res_reg <= res_in;
            rre_reg <= rre_next;
            rim_reg <= rim_next;
            d_reg   <= d_in;
            qre_reg <= qre_next;
            qim_reg <= qim_next;
        end
    end

    assign v_out   = v_reg;
    assign ctl_out = ctl_reg;
    assign res_out = res_reg;
    assign rre_out = rre_reg;
    assign rim_out = rim_reg;
    assign d_out   = d_reg;
    assign qre_out = qre_reg;
    assign qim_out = qim_reg;

endmodule

>>> rtl/complex_arith_unit.sv
// Complex arithmetic unit: add, subtract, multiply or divide two complex
// operands in signed fixed point, one beat in, one beat out.
// Input channel s_valid/s_ready/s_data carries the opcode and a, b; the
// result channel m_valid/m_ready/m_data carries res_re, res_im and status
// (ok, saturated, divide by zero).
// Throughput: one beat per cycle while m_ready stays high, for every opcode mixed freely.
// Path from input beat to result valid: input register, multiplier
// register, operand prep register, one cell per quotient bit (DATA_WIDTH
// cells), output register. Every opcode travels the full chain so
// results leave in order.
// Division runs as a chain of restoring-divider cells, each settling one
// quotient bit for both parts per cycle when not stalled, handing the remainder on.
// Reset (aresetn low, synchronous) empties every stage; any result still
// in flight is dropped.
// When the receiver stalls, each stage holds only while the stage ahead is
// full, so bubbles close up and s_ready drops once the chain is full.
module complex_arith_unit import cau_pkg::*; #(
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cau_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cau_out_t m_data
);

    localparam int DW = CAU_DATA_WIDTH;
    localparam int MW = CAU_MAG_WIDTH;
    localparam int RW = CAU_REM_WIDTH;
    localparam int PW = 2 * DW;

    // stage 1: input register
    logic    v1_reg, rdy1;
    cau_in_t in_reg;

    // stage 2: products
    logic                 v2_reg, rdy2;
    cau_cmd_t             cmd2_reg;
    logic signed [DW-1:0] ar2_reg, ai2_reg, br2_reg, bi2_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg, pbb_reg, pcc_reg;

    // stage 3: prep
    logic     v3_reg, rdy3;
    cau_ctl_t ctl3_reg, ctl3_next;
    cau_out_t res3_reg, res3_next;
    logic [RW-1:0] rre3_reg, rim3_reg, rre3_next, rim3_next;
    logic [MW-1:0] d3_reg, d3_next;

    // cell chain wiring, index 0 is the prep stage
    logic          v_w   [DW+1];
    logic          rdy_w [DW+1];
    cau_ctl_t      ctl_w [DW+1];
    cau_out_t      res_w [DW+1];
    logic [RW-1:0] rre_w [DW+1];
    logic [RW-1:0] rim_w [DW+1];
    logic [MW-1:0] d_w   [DW+1];
    logic [DW-1:0] qre_w [DW+1];
    logic [DW-1:0] qim_w [DW+1];

    // output register
    logic     m_valid_reg;
    cau_out_t m_data_reg, m_data_next;

    // ready ripples back: a stage may load when empty or when it drains
    assign rdy_w[DW] = !m_valid_reg || m_ready;
    assign rdy3      = !v3_reg || rdy_w[0];
    assign rdy2      = !v2_reg || rdy3;
    assign rdy1      = !v1_reg || rdy2;
    assign s_ready   = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1)      v1_reg      <= s_valid;
            if (rdy2)      v2_reg      <= v1_reg;
            if (rdy3)      v3_reg      <= v2_reg;
            if (rdy_w[DW]) m_valid_reg <= v_w[DW];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            in_reg <= s_data;
        end
    end

    // form all six products at full precision
    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            cmd2_reg <= in_reg.cmd;
            ar2_reg  <= in_reg.a_re;
            ai2_reg  <= in_reg.a_im;
            br2_reg  <= in_reg.b_re;
            bi2_reg  <= in_reg.b_im;
            prr_reg  <= in_reg.a_re * in_reg.b_re;
            pii_reg  <= in_reg.a_im * in_reg.b_im;
            pri_reg  <= in_reg.a_re * in_reg.b_im;
            pir_reg  <= in_reg.a_im * in_reg.b_re;
            pbb_reg  <= in_reg.b_re * in_reg.b_re;
            pcc_reg  <= in_reg.b_im * in_reg.b_im;
        end
    end

    // Prep: finish add, subtract and multiply here; for divide set up the
    // scaled numerator magnitudes, the divisor and the range check.
    logic signed [DW:0]   sre, sim;
    logic signed [MW-1:0] xre, xim;
    logic [MW-1:0]        mre, mim, tre, tim;
    logic [RW-1:0]        nre, nim, dlim;
    cau_sat_t             sat_re, sat_im;
    logic                 nre_neg, nim_neg;

    always_comb begin
        ctl3_next = '0;
        res3_next = '0;
        rre3_next = '0;
        rim3_next = '0;
        d3_next   = MW'({1'b0, pbb_reg}) + MW'({1'b0, pcc_reg});
        sre       = '0;
        sim       = '0;
        xre       = '0;
        xim       = '0;
        nre_neg   = 1'b0;
        nim_neg   = 1'b0;
        case (cmd2_reg)
            CMD_ADD: begin
                sre = {ar2_reg[DW-1], ar2_reg} + {br2_reg[DW-1], br2_reg};
                sim = {ai2_reg[DW-1], ai2_reg} + {bi2_reg[DW-1], bi2_reg};
                xre = {{(MW-DW-1){sre[DW]}}, sre};
                xim = {{(MW-DW-1){sim[DW]}}, sim};
            end
            CMD_SUB: begin
                sre = {ar2_reg[DW-1], ar2_reg} - {br2_reg[DW-1], br2_reg};
                sim = {ai2_reg[DW-1], ai2_reg} - {bi2_reg[DW-1], bi2_reg};
                xre = {{(MW-DW-1){sre[DW]}}, sre};
                xim = {{(MW-DW-1){sim[DW]}}, sim};
            end
            CMD_MUL: begin
                xre = {prr_reg[PW-1], prr_reg} - {pii_reg[PW-1], pii_reg};
                xim = {pri_reg[PW-1], pri_reg} + {pir_reg[PW-1], pir_reg};
            end
            default: begin
                xre = {prr_reg[PW-1], prr_reg} + {pii_reg[PW-1], pii_reg};
                xim = {pir_reg[PW-1], pir_reg} - {pri_reg[PW-1], pri_reg};
            end
        endcase
        mre = cau_abs(xre);
        mim = cau_abs(xim);
        // multiply rescale truncates the magnitude
        tre = (cmd2_reg == CMD_MUL) ? (mre >> FRAC_BITS) : mre;
        tim = (cmd2_reg == CMD_MUL) ? (mim >> FRAC_BITS) : mim;
        nre_neg = xre[MW-1] && (tre != '0);
        nim_neg = xim[MW-1] && (tim != '0);
        sat_re  = cau_sat(nre_neg, tre);
        sat_im  = cau_sat(nim_neg, tim);
        nre     = RW'(mre) << FRAC_BITS;
        nim     = RW'(mim) << FRAC_BITS;
        dlim    = RW'(d3_next) << DW;

        res3_next.res_re = sat_re.val;
        res3_next.res_im = sat_im.val;
        res3_next.status = (sat_re.flag || sat_im.flag) ? ST_SAT : ST_OK;
        if (cmd2_reg == CMD_DIV) begin
            if (d3_next == '0) begin
                res3_next = '{res_re: '0, res_im: '0, status: ST_DZ};
            end else begin
                ctl3_next.div    = 1'b1;
                ctl3_next.neg_re = xre[MW-1];
                ctl3_next.neg_im = xim[MW-1];
                // quotient would need more than DW bits: saturate outright
                ctl3_next.ovf_re = nre >= dlim;
                ctl3_next.ovf_im = nim >= dlim;
                rre3_next        = ctl3_next.ovf_re ? '0 : nre;
                rim3_next        = ctl3_next.ovf_im ? '0 : nim;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            ctl3_reg <= ctl3_next;
            res3_reg <= res3_next;
            rre3_reg <= rre3_next;
            rim3_reg <= rim3_next;
            d3_reg   <= d3_next;
        end
    end

    assign v_w[0]   = v3_reg;
    assign ctl_w[0] = ctl3_reg;
    assign res_w[0] = res3_reg;
    assign rre_w[0] = rre3_reg;
    assign rim_w[0] = rim3_reg;
    assign d_w[0]   = d3_reg;
    assign qre_w[0] = '0;
    assign qim_w[0] = '0;

    // one cell per quotient bit, most significant first
    for (genvar i = 0; i < DW; i++) begin : g_cell
        cau_cell #(
            .SHIFT(DW - 1 - i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .v_in    (v_w[i]),
            .rdy_out (rdy_w[i]),
            .ctl_in  (ctl_w[i]),
            .res_in  (res_w[i]),
            .rre_in  (rre_w[i]),
            .rim_in  (rim_w[i]),
            .d_in    (d_w[i]),
            .qre_in  (qre_w[i]),
            .qim_in  (qim_w[i]),
            .v_out   (v_w[i+1]),
            .rdy_in  (rdy_w[i+1]),
            .ctl_out (ctl_w[i+1]),
            .res_out (res_w[i+1]),
            .rre_out (rre_w[i+1]),
            .rim_out (rim_w[i+1]),
            .d_out   (d_w[i+1]),
            .qre_out (qre_w[i+1]),
            .qim_out (qim_w[i+1])
        );
    end

    // apply the sign to the quotient and saturate; other ops pass through
    cau_sat_t      qsat_re, qsat_im;
    logic [MW-1:0] qmag_re, qmag_im;

    always_comb begin
        qmag_re = ctl_w[DW].ovf_re ? {MW{1'b1}} : MW'(qre_w[DW]);
        qmag_im = ctl_w[DW].ovf_im ? {MW{1'b1}} : MW'(qim_w[DW]);
        qsat_re = cau_sat(ctl_w[DW].neg_re && (qmag_re != '0), qmag_re);
        qsat_im = cau_sat(ctl_w[DW].neg_im && (qmag_im != '0), qmag_im);
        if (ctl_w[DW].div) begin
            m_data_next.res_re = qsat_re.val;
            m_data_next.res_im = qsat_im.val;
            m_data_next.status = (qsat_re.flag || qsat_im.flag) ? ST_SAT : ST_OK;
        end else begin
            m_data_next = res_w[DW];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_w[DW] && v_w[DW]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> test/tb_complex_arith_unit.sv
module tb_complex_arith_unit;
    import cau_pkg::*;

    localparam int DW         = CAU_DATA_WIDTH;
    localparam int FB         = CAU_FRAC_BITS;
    localparam int LATENCY    = DW + 4;
    localparam int IDLE_LIMIT = 5000;
    localparam longint POS_MAX = (64'sd1 <<< (DW - 1)) - 1;
    localparam longint NEG_MIN = -(64'sd1 <<< (DW - 1));

    // Expected complex results, in input beat order, with the arithmetic
    // that produces them.
    class cplx_scoreboard;
        cau_out_t pending_q[$];

        // Clamp one part to the signed data range, flag any clipping.
        function automatic logic [DW-1:0] clamp(longint v, ref bit flag);
            if (v > POS_MAX) begin
                flag = 1'b1;
                return POS_MAX[DW-1:0];
            end
            if (v < NEG_MIN) begin
                flag = 1'b1;
                return NEG_MIN[DW-1:0];
            end
            return v[DW-1:0];
        endfunction

        function void note(cau_in_t x);
            longint   ar, ai, br, bi, re, im, d;
            bit       flag;
            cau_out_t r;
            ar   = longint'(x.a_re);
            ai   = longint'(x.a_im);
            br   = longint'(x.b_re);
            bi   = longint'(x.b_im);
            flag = 1'b0;
            re   = 0;
            im   = 0;
            case (x.cmd)
                CMD_ADD: begin
                    re = ar + br;
                    im = ai + bi;
                end
                CMD_SUB: begin
                    re = ar - br;
                    im = ai - bi;
                end
                CMD_MUL: begin
                    // full-precision products, then rescale toward zero
                    re = (ar * br - ai * bi) / (64'sd1 <<< FB);
                    im = (ar * bi + br * ai) / (64'sd1 <<< FB);
                end
                default: begin
                    d = br * br + bi * bi;
                    if (d == 0) begin
                        r.res_re = '0;
                        r.res_im = '0;
                        r.status = ST_DZ;
                        pending_q.push_back(r);
                        return;
                    end
                    // conjugate numerators, scaled up before the quotient
                    re = ((ar * br + ai * bi) * (64'sd1 <<< FB)) / d;
                    im = ((br * ai - ar * bi) * (64'sd1 <<< FB)) / d;
                end
            endcase
            r.res_re = clamp(re, flag);
            r.res_im = clamp(im, flag);
            r.status = flag ? ST_SAT : ST_OK;
            pending_q.push_back(r);
        endfunction

        function bit check(cau_out_t got, output string why);
            cau_out_t exp_r;
            why = "";
            if (pending_q.size() == 0) begin
                why = "result beat with nothing outstanding";
                return 1'b0;
            end
            exp_r = pending_q.pop_front();
            if (got.res_re !== exp_r.res_re)
                why = $sformatf("%s res_re got %0d exp %0d", why, got.res_re, exp_r.res_re);
            if (got.res_im !== exp_r.res_im)
                why = $sformatf("%s res_im got %0d exp %0d", why, got.res_im, exp_r.res_im);
            if (got.status !== exp_r.status)
                why = $sformatf("%s status got %0d exp %0d", why, got.status, exp_r.status);
            return why == "";
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    cau_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    cau_out_t m_data;

    cplx_scoreboard sb;
    int  errors;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_cycles;
    int  quiet_cycles;

    complex_arith_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report(string msg);
        $display("mismatch @%0t:%s", $time, msg);
        errors++;
    endtask

    // Monitor: note every accepted input beat, check every accepted result
    // beat, and bail out if the unit goes quiet for too long.
    always @(posedge aclk) begin
        string why;
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note(s_data);
            if (m_valid && m_ready) begin
                if (!sb.check(m_data, why))
                    report(why);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: a long hold-off takes priority, otherwise stall at random.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one beat, idling first at the current rate; hold it until taken.
    task automatic send_beat(cau_in_t item);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic send_op(cau_cmd_t c, int ar, int ai, int br, int bi);
        cau_in_t item;
        item.cmd  = c;
        item.a_re = ar[DW-1:0];
        item.a_im = ai[DW-1:0];
        item.b_re = br[DW-1:0];
        item.b_im = bi[DW-1:0];
        send_beat(item);
    endtask

    function automatic logic [DW-1:0] rand_part();
        case ($urandom_range(7))
            0, 1: return DW'($urandom);
            2: begin
                case ($urandom_range(4))
                    0: return POS_MAX[DW-1:0];
                    1: return NEG_MIN[DW-1:0];
                    2: return '0;
                    3: return '1;
                    default: return DW'(1);
                endcase
            end
            3: return DW'($urandom_range(8191)) - DW'(4096);
            default: return DW'($urandom_range(1023)) - DW'(512);
        endcase
    endfunction

    function automatic cau_in_t rand_item();
        cau_in_t item;
        item.cmd  = cau_cmd_t'($urandom_range(3));
        item.a_re = rand_part();
        item.a_im = rand_part();
        item.b_re = rand_part();
        item.b_im = rand_part();
        // hit the zero divisor now and then
        if (item.cmd == CMD_DIV && $urandom_range(15) == 0) begin
            item.b_re = '0;
            item.b_im = '0;
        end
        return item;
    endfunction

    task automatic drain();
        while (sb.outstanding() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_beat(rand_item());
    endtask

    initial begin
        sb             = new();
        errors         = 0;
        quiet_cycles   = 0;
        hold_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        aresetn        = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: range edges of every operation, saturation both ways,
        // zero divisor and truncation toward zero.
        send_op(CMD_ADD, 32767, -32768, 32767, -32768);
        send_op(CMD_ADD, 1, -1, -1, 1);
        send_op(CMD_ADD, 0, 0, 0, 0);
        send_op(CMD_SUB, -32768, 32767, 32767, -32768);
        send_op(CMD_SUB, 100, -100, 100, -100);
        send_op(CMD_SUB, -1, 0, -32768, 0);
        send_op(CMD_MUL, -32768, -32768, -32768, -32768);
        send_op(CMD_MUL, 32767, 32767, 32767, -32768);
        send_op(CMD_MUL, 256, 0, 256, 0);
        send_op(CMD_MUL, -1, 1, 1, 1);
        send_op(CMD_MUL, 0, 0, 32767, -32768);
        send_op(CMD_MUL, -300, 200, 5, -7);
        send_op(CMD_DIV, 256, 256, 0, 0);
        send_op(CMD_DIV, 32767, -32768, 0, 0);
        send_op(CMD_DIV, 256, 0, 256, 0);
        send_op(CMD_DIV, -32768, -32768, 1, 0);
        send_op(CMD_DIV, 1, 0, 32767, 32767);
        send_op(CMD_DIV, -5, 3, 768, -512);
        send_op(CMD_DIV, 32767, 32767, -32768, -32768);
        send_op(CMD_DIV, 0, 0, -1, 0);
        send_op(CMD_DIV, -1000, 700, 0, 1);

        run_phase(0, 0, 350);
        run_phase(57, 0, 350);
        run_phase(0, 57, 350);
        run_phase(24, 24, 350);

        // Back-pressure: hold the receiver off long enough to fill the chain
        // while beats keep coming at full rate.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 200;
        repeat (60)
            send_beat(rand_item());

        // Pause until the chain is empty, then pick up again.
        @(negedge aclk);
        s_valid <= 1'b0;
        drain();
        run_phase(10, 10, 100);

        @(negedge aclk);
        s_valid <= 1'b0;
        drain();
        repeat (LATENCY * 2) @(posedge aclk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/cau_pkg.sv
rtl/cau_cell.sv
rtl/complex_arith_unit.sv
test/tb_complex_arith_unit.sv
